### hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the quaternion converter top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define RMQ_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("rmq: assertion failed");
// Check that a condition in one cycle brings a consequence in the next.
`define RMQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rmq: assertion failed");
`else
`define RMQ_ASSERT_ALWAYS(lbl, cond)
`define RMQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hw/rtl/rmq_pkg.sv
// Types and constants shared by the quaternion converter modules.
`timescale 1ns / 1ps
package rmq_pkg;

  localparam int DIFF_W = 33;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
  } rmq_in_t;

  typedef struct packed {
    logic signed [31:0] q_w;
    logic signed [31:0] q_x;
    logic signed [31:0] q_y;
    logic signed [31:0] q_z;
    logic               invalid;
  } rmq_out_t;

  // Which component takes the half root
  localparam logic [1:0] ROLE_W = 2'd0;
  localparam logic [1:0] ROLE_X = 2'd1;
  localparam logic [1:0] ROLE_Y = 2'd2;
  localparam logic [1:0] ROLE_Z = 2'd3;

  typedef struct packed {
    logic [1:0] role;
    logic       bad;
  } rmq_ctl_t;

endpackage

### hw/rtl/rmq_prep.sv
// Front stage: trace, pivot choice, root argument and off-diagonal terms.
`timescale 1ns / 1ps
module rmq_prep
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS = 30,
  parameter int AW        = 35,
  parameter int RW        = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  rmq_in_t                  in_data,
  output logic                     valid,
  output logic [RW-1:0]            rad,
  output rmq_ctl_t                 ctl,
  output logic signed [DIFF_W-1:0] da,
  output logic signed [DIFF_W-1:0] db,
  output logic signed [DIFF_W-1:0] dc
);

  localparam logic [AW-1:0] ONE_A =
    {{(AW-1-FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  logic signed [AW-1:0] e00, e11, e22, trace, arg;
  logic signed [DIFF_W-1:0] da_next, db_next, dc_next;
  logic [1:0] role_next;
  logic piv1, piv2;

  // Pick the branch and form the root argument and the three numerators
  always_comb begin
    e00   = AW'(in_data.m00);
    e11   = AW'(in_data.m11);
    e22   = AW'(in_data.m22);
    trace = e00 + e11 + e22;
    piv1  = in_data.m11 > in_data.m00;
    piv2  = piv1 ? (in_data.m22 > in_data.m11) : (in_data.m22 > in_data.m00);
    if (!trace[AW-1]) begin
      role_next = ROLE_W;
      arg       = trace + ONE_A;
      da_next   = DIFF_W'(in_data.m21) - DIFF_W'(in_data.m12);
      db_next   = DIFF_W'(in_data.m02) - DIFF_W'(in_data.m20);
      dc_next   = DIFF_W'(in_data.m10) - DIFF_W'(in_data.m01);
    end else if (piv2) begin
      role_next = ROLE_Z;
      arg       = e22 - e00 - e11 + ONE_A;
      da_next   = DIFF_W'(in_data.m10) - DIFF_W'(in_data.m01);
      db_next   = DIFF_W'(in_data.m02) + DIFF_W'(in_data.m20);
      dc_next   = DIFF_W'(in_data.m12) + DIFF_W'(in_data.m21);
    end else if (piv1) begin
      role_next = ROLE_Y;
      arg       = e11 - e22 - e00 + ONE_A;
      da_next   = DIFF_W'(in_data.m02) - DIFF_W'(in_data.m20);
      db_next   = DIFF_W'(in_data.m21) + DIFF_W'(in_data.m12);
      dc_next   = DIFF_W'(in_data.m01) + DIFF_W'(in_data.m10);
    end else begin
      role_next = ROLE_X;
      arg       = e00 - e11 - e22 + ONE_A;
      da_next   = DIFF_W'(in_data.m21) - DIFF_W'(in_data.m12);
      db_next   = DIFF_W'(in_data.m10) + DIFF_W'(in_data.m01);
      dc_next   = DIFF_W'(in_data.m20) + DIFF_W'(in_data.m02);
    end
  end

  // Hold the request valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    if (en) begin
      rad      <= {arg[AW-2:0], {FRAC_BITS{1'b0}}};
      ctl.role <= role_next;
      ctl.bad  <= arg[AW-1] | (arg == '0);
      da       <= da_next;
      db       <= db_next;
      dc       <= dc_next;
    end
  end

endmodule

### hw/rtl/rmq_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module rmq_sqrt #(
  parameter int RW = 64,
  parameter int SW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [RW-1:0] rad,
  output logic [SW-1:0] root
);

  localparam int RP  = 2 * SW;
  localparam int RMW = SW + 3;

  logic [RMW-1:0] rem_q  [1:SW-1];
  logic [RP-1:0]  rad_q  [1:SW-1];
  logic [SW-1:0]  root_q [1:SW];

  for (genvar g = 0; g < SW; g++) begin : g_stage
    logic [RMW-1:0] rem_i, acc, trial, diff;
    logic [RP-1:0]  rad_i;
    logic [SW-1:0]  root_i;
    logic           ge;

    if (g == 0) begin : g_first
      assign rem_i  = '0;
      assign rad_i  = RP'(rad);
      assign root_i = '0;
    end else begin : g_mid
      assign rem_i  = rem_q[g];
      assign rad_i  = rad_q[g];
      assign root_i = root_q[g];
    end

    // Bring down two radicand bits and try the next root bit
    assign acc   = {rem_i[RMW-3:0], rad_i[RP-1 -: 2]};
    assign trial = {1'b0, root_i, 2'b01};
    assign ge    = acc >= trial;
    assign diff  = acc - trial;

    always_ff @(posedge clk) begin
      if (en) begin
        root_q[g+1] <= {root_i[SW-2:0], ge};
      end
    end

    if (g < SW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[g+1] <= ge ? diff : acc;
          rad_q[g+1] <= {rad_i[RP-3:0], 2'b00};
        end
      end
    end
  end

  assign root = root_q[SW];

endmodule

### hw/rtl/rmq_div.sv
// Pipelined restoring divider: fraction of |d| over the doubled root.
`timescale 1ns / 1ps
module rmq_div
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS = 30,
  parameter int DW        = 33
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [DIFF_W-1:0]    mag,
  input  logic [DW-1:0]        den,
  output logic [FRAC_BITS-1:0] quo,
  output logic                 sat
);

  localparam int CW = DW + DIFF_W;

  logic [DW-1:0]        rem_q [1:FRAC_BITS-1];
  logic [DW-1:0]        den_q [1:FRAC_BITS-1];
  logic [FRAC_BITS-1:0] quo_q [1:FRAC_BITS];
  logic                 sat_q [1:FRAC_BITS];

  for (genvar g = 0; g < FRAC_BITS; g++) begin : g_stage
    logic [DW-1:0]        rem_i, den_i;
    logic [FRAC_BITS-1:0] quo_i;
    logic                 sat_i, ge;
    logic [DW:0]          r2, diff;

    if (g == 0) begin : g_first
      // A quotient of one or more saturates
      assign sat_i = CW'(mag) >= CW'(den);
      assign rem_i = sat_i ? '0 : DW'(mag);
      assign den_i = den;
      assign quo_i = '0;
    end else begin : g_mid
      assign sat_i = sat_q[g];
      assign rem_i = rem_q[g];
      assign den_i = den_q[g];
      assign quo_i = quo_q[g];
    end

    // Shift the remainder and try one subtraction
    assign r2   = {rem_i, 1'b0};
    assign ge   = r2 >= {1'b0, den_i};
    assign diff = r2 - {1'b0, den_i};

    always_ff @(posedge clk) begin
      if (en) begin
        quo_q[g+1] <= {quo_i[FRAC_BITS-2:0], ge};
        sat_q[g+1] <= sat_i;
      end
    end

    if (g < FRAC_BITS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[g+1] <= ge ? diff[DW-1:0] : r2[DW-1:0];
          den_q[g+1] <= den_i;
        end
      end
    end
  end

  assign quo = quo_q[FRAC_BITS];
  assign sat = sat_q[FRAC_BITS];

endmodule

### hw/rtl/rotation_matrix_to_quaternion_top.sv
// Rotation matrix to quaternion: front stage, root and divider pipelines and
// output register, with SW = (FRAC_BITS + max(34, FRAC_BITS + 1) + 1) / 2
// root bits (32 at 30).
// Throughput one request per cycle: one pipeline stage per root bit and per
// quotient bit, all stages advance together when the output is free.
// Reset (rst, synchronous) clears the valid bits only; no memories to clear.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_top
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS = 30
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  rmq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output rmq_out_t out_data
);

`include "assert_macros.svh"

  localparam int AW = (FRAC_BITS + 2 > 35) ? FRAC_BITS + 2 : 35;
  localparam int RW = AW - 1 + FRAC_BITS;
  localparam int SW = (RW + 1) / 2;
  localparam int DW = SW + 1;
  localparam int VW = FRAC_BITS + 2;
  localparam int PW = ((SW > VW) ? SW : VW) + 1;
  localparam logic [VW-1:0] ONE_V = {2'b01, {FRAC_BITS{1'b0}}};
  localparam logic signed [63:0] ONE_CMP = 64'sd1 <<< FRAC_BITS;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Front stage
  logic                     p_valid;
  logic [RW-1:0]            p_rad;
  rmq_ctl_t                 p_ctl;
  logic signed [DIFF_W-1:0] p_da, p_db, p_dc;

  rmq_prep #(.FRAC_BITS(FRAC_BITS), .AW(AW), .RW(RW)) u_prep (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid), .in_data(in_data),
    .valid(p_valid), .rad(p_rad), .ctl(p_ctl), .da(p_da), .db(p_db), .dc(p_dc)
  );

  // Root pipeline
  logic [SW-1:0] root;
  rmq_sqrt #(.RW(RW), .SW(SW)) u_sqrt (
    .clk(clk), .en(en), .rad(p_rad), .root(root)
  );

  // Sideband alongside the root pipeline
  logic                     s_valid [1:SW];
  rmq_ctl_t                 s_ctl   [1:SW];
  logic signed [DIFF_W-1:0] s_da    [1:SW];
  logic signed [DIFF_W-1:0] s_db    [1:SW];
  logic signed [DIFF_W-1:0] s_dc    [1:SW];

  for (genvar g = 0; g < SW; g++) begin : g_sside
    logic                     v_i;
    rmq_ctl_t                 c_i;
    logic signed [DIFF_W-1:0] a_i, b_i, d_i;
    if (g == 0) begin : g_first
      assign v_i = p_valid;
      assign c_i = p_ctl;
      assign a_i = p_da;
      assign b_i = p_db;
      assign d_i = p_dc;
    end else begin : g_mid
      assign v_i = s_valid[g];
      assign c_i = s_ctl[g];
      assign a_i = s_da[g];
      assign b_i = s_db[g];
      assign d_i = s_dc[g];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        s_valid[g+1] <= 1'b0;
      end else if (en) begin
        s_valid[g+1] <= v_i;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        s_ctl[g+1] <= c_i;
        s_da[g+1]  <= a_i;
        s_db[g+1]  <= b_i;
        s_dc[g+1]  <= d_i;
      end
    end
  end

  // Magnitudes of the numerators
  logic [DIFF_W-1:0] mag_a, mag_b, mag_c;
  assign mag_a = s_da[SW][DIFF_W-1] ? DIFF_W'(-s_da[SW]) : DIFF_W'(s_da[SW]);
  assign mag_b = s_db[SW][DIFF_W-1] ? DIFF_W'(-s_db[SW]) : DIFF_W'(s_db[SW]);
  assign mag_c = s_dc[SW][DIFF_W-1] ? DIFF_W'(-s_dc[SW]) : DIFF_W'(s_dc[SW]);

  logic [DW-1:0] den;
  assign den = {root, 1'b0};

  logic [FRAC_BITS-1:0] quo_a, quo_b, quo_c;
  logic                 sat_a, sat_b, sat_c;

  rmq_div #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_div_a (
    .clk(clk), .en(en), .mag(mag_a), .den(den), .quo(quo_a), .sat(sat_a)
  );
  rmq_div #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_div_b (
    .clk(clk), .en(en), .mag(mag_b), .den(den), .quo(quo_b), .sat(sat_b)
  );
  rmq_div #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_div_c (
    .clk(clk), .en(en), .mag(mag_c), .den(den), .quo(quo_c), .sat(sat_c)
  );

  // Sideband alongside the divider pipeline
  logic          d_valid [1:FRAC_BITS];
  rmq_ctl_t      d_ctl   [1:FRAC_BITS];
  logic [2:0]    d_neg   [1:FRAC_BITS];
  logic [SW-1:0] d_root  [1:FRAC_BITS];

  for (genvar g = 0; g < FRAC_BITS; g++) begin : g_dside
    logic          v_i;
    rmq_ctl_t      c_i;
    logic [2:0]    n_i;
    logic [SW-1:0] r_i;
    if (g == 0) begin : g_first
      assign v_i = s_valid[SW];
      assign c_i = s_ctl[SW];
      assign n_i = {s_dc[SW][DIFF_W-1], s_db[SW][DIFF_W-1], s_da[SW][DIFF_W-1]};
      assign r_i = root;
    end else begin : g_mid
      assign v_i = d_valid[g];
      assign c_i = d_ctl[g];
      assign n_i = d_neg[g];
      assign r_i = d_root[g];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        d_valid[g+1] <= 1'b0;
      end else if (en) begin
        d_valid[g+1] <= v_i;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d_ctl[g+1]  <= c_i;
        d_neg[g+1]  <= n_i;
        d_root[g+1] <= r_i;
      end
    end
  end

  function automatic logic [31:0] to_out(input logic [VW-1:0] v);
    logic [VW+31:0] x;
    x = {{32{v[VW-1]}}, v};
    return x[31:0];
  endfunction

  function automatic logic [VW-1:0] lane_val(input logic [FRAC_BITS-1:0] q,
                                             input logic s, input logic n);
    logic [VW-1:0] m;
    m = s ? ONE_V : VW'(q);
    return n ? VW'(-m) : m;
  endfunction

  // Assemble the quaternion from the half root and the three quotients
  logic [SW-1:0] piv_h;
  logic [VW-1:0] piv, va, vb, vc;
  rmq_out_t      out_next;
  rmq_ctl_t      f_ctl;

  always_comb begin
    f_ctl = d_ctl[FRAC_BITS];
    piv_h = d_root[FRAC_BITS] >> 1;
    piv   = (PW'(piv_h) > PW'(ONE_V)) ? ONE_V : VW'(piv_h);
    va    = lane_val(quo_a, sat_a, d_neg[FRAC_BITS][0]);
    vb    = lane_val(quo_b, sat_b, d_neg[FRAC_BITS][1]);
    vc    = lane_val(quo_c, sat_c, d_neg[FRAC_BITS][2]);
    out_next.invalid = f_ctl.bad;
    case (f_ctl.role)
      ROLE_W: begin
        out_next.q_w = to_out(piv);
        out_next.q_x = to_out(va);
        out_next.q_y = to_out(vb);
        out_next.q_z = to_out(vc);
      end
      ROLE_X: begin
        out_next.q_w = to_out(va);
        out_next.q_x = to_out(piv);
        out_next.q_y = to_out(vb);
        out_next.q_z = to_out(vc);
      end
      ROLE_Y: begin
        out_next.q_w = to_out(va);
        out_next.q_x = to_out(vc);
        out_next.q_y = to_out(piv);
        out_next.q_z = to_out(vb);
      end
      default: begin
        out_next.q_w = to_out(va);
        out_next.q_x = to_out(vb);
        out_next.q_y = to_out(vc);
        out_next.q_z = to_out(piv);
      end
    endcase
    // Drop the components of a matrix whose root argument is not positive
    if (f_ctl.bad) begin
      out_next.q_w = '0;
      out_next.q_x = '0;
      out_next.q_y = '0;
      out_next.q_z = '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_valid[FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= out_next;
    end
  end

  // Terms for the checks below
  logic q_zero, w_ok;
  assign q_zero = (out_data.q_w == '0) && (out_data.q_x == '0) &&
                  (out_data.q_y == '0) && (out_data.q_z == '0);
  assign w_ok   = (FRAC_BITS > 30) ||
                  ((64'($signed(out_data.q_w)) <= ONE_CMP) &&
                   (64'($signed(out_data.q_w)) >= -ONE_CMP));

  `RMQ_ASSERT_NEXT(a_front_fill, in_valid && in_ready, p_valid)
  `RMQ_ASSERT_ALWAYS(a_invalid_zero, !(out_valid && out_data.invalid) || q_zero)
  `RMQ_ASSERT_ALWAYS(a_w_range, !out_valid || w_ok)

endmodule

### dv/rmq_checker.sv
// Checker for the quaternion converter: predicts each quaternion and compares it.
`timescale 1ns / 1ps
module rmq_checker
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS = 30
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_ready,
  input  rmq_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  rmq_out_t out_data,
  output int       fail_count,
  output int       pending
);

  localparam longint ONE = longint'(1) << FRAC_BITS;

  rmq_out_t quat_queue[$];

  // Scale d by one and divide by den, truncating toward zero; clamp at +-one.
  function automatic longint scaled_ratio(longint d, longint unsigned den);
    longint unsigned mag;
    logic [127:0]    quo;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    if (mag >= den) return (d < 0) ? -ONE : ONE;
    quo = ({64'd0, mag} << FRAC_BITS) / {64'd0, den};
    return (d < 0) ? -longint'(quo[63:0]) : longint'(quo[63:0]);
  endfunction

  // Shepperd conversion of one matrix to its quaternion.
  function automatic rmq_out_t matrix_to_quat(rmq_in_t r);
    longint          mm[9];
    longint          q[4];
    longint          tr, arg, piv;
    longint unsigned s, den;
    logic [127:0]    rad, cand;
    int              i, j, k;
    rmq_out_t        res;
    mm[0] = r.m00; mm[1] = r.m01; mm[2] = r.m02;
    mm[3] = r.m10; mm[4] = r.m11; mm[5] = r.m12;
    mm[6] = r.m20; mm[7] = r.m21; mm[8] = r.m22;
    q = '{0, 0, 0, 0};
    i = 0;
    if (mm[4] > mm[0]) i = 1;
    if (mm[8] > mm[i*4]) i = 2;
    j = (i + 1) % 3;
    k = (j + 1) % 3;
    tr = mm[0] + mm[4] + mm[8];
    arg = (tr >= 0) ? tr + ONE : mm[i*4] - mm[j*4] - mm[k*4] + ONE;
    res = '0;
    if (arg <= 0) begin
      res.invalid = 1'b1;
      return res;
    end
    // floor of the root of arg scaled by one
    rad = {64'd0, arg} << FRAC_BITS;
    s = 0;
    for (int b = 62; b >= 0; b--) begin
      cand = {64'd0, s | (64'd1 << b)};
      if (cand * cand <= rad) s = cand[63:0];
    end
    den = s << 1;
    piv = longint'(s >> 1);
    if (piv > ONE) piv = ONE;
    if (tr >= 0) begin
      q[0] = piv;
      q[1] = scaled_ratio(mm[7] - mm[5], den);
      q[2] = scaled_ratio(mm[2] - mm[6], den);
      q[3] = scaled_ratio(mm[3] - mm[1], den);
    end else begin
      q[1+i] = piv;
      q[0]   = scaled_ratio(mm[k*3+j] - mm[j*3+k], den);
      q[1+j] = scaled_ratio(mm[j*3+i] + mm[i*3+j], den);
      q[1+k] = scaled_ratio(mm[k*3+i] + mm[i*3+k], den);
    end
    res.q_w = q[0][31:0];
    res.q_x = q[1][31:0];
    res.q_y = q[2][31:0];
    res.q_z = q[3][31:0];
    return res;
  endfunction

  function automatic int field_differs(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v === act_v) return 0;
    $error("%s: expected %h, got %h", name, exp_v, act_v);
    return 1;
  endfunction

  // Predict on each accepted request, compare on each accepted result.
  always @(posedge clk) begin
    rmq_out_t want;
    int       errs;
    if (rst) begin
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (in_valid && in_ready) quat_queue.push_back(matrix_to_quat(in_data));
      if (out_valid && out_ready) begin
        if (quat_queue.size() == 0) begin
          $error("quaternion arrived with none expected");
          fail_count <= fail_count + 1;
        end else begin
          want = quat_queue.pop_front();
          errs = field_differs("q_w", want.q_w, out_data.q_w)
               + field_differs("q_x", want.q_x, out_data.q_x)
               + field_differs("q_y", want.q_y, out_data.q_y)
               + field_differs("q_z", want.q_z, out_data.q_z)
               + field_differs("invalid", 32'(want.invalid), 32'(out_data.invalid));
          if (errs != 0) fail_count <= fail_count + errs;
        end
      end
      pending <= quat_queue.size();
    end
  end

endmodule

### dv/tb_rotation_matrix_to_quaternion_top.sv
// Testbench top: drives matrices and back-pressure, gives the verdict.
`timescale 1ns / 1ps
module tb_rotation_matrix_to_quaternion_top;
  import rmq_pkg::*;

  localparam int     ITEMS  = 1200;
  localparam int     LIMIT  = 5000;
  localparam longint ONE    = longint'(1) << 30;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  rmq_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  rmq_out_t out_data;
  int       fail_count, pending;
  int       cyc = 0;
  int       quiet = 0;
  bit       sent_all = 1'b0;

  always #5 clk = ~clk;

  rotation_matrix_to_quaternion_top DUT (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data
  );

  rmq_checker CHK (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .fail_count, .pending
  );

  function automatic logic [31:0] fx(real v);
    longint t;
    t = $rtoi(v * real'(ONE));
    if (t > ONE) t = ONE;
    if (t < -ONE) t = -ONE;
    return t[31:0];
  endfunction

  function automatic rmq_in_t diag(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    rmq_in_t r;
    r = '0;
    r.m00 = a; r.m11 = b; r.m22 = c;
    return r;
  endfunction

  function automatic real unit_rand();
    return (real'($urandom_range(2000000)) - 1000000.0) / 1000000.0;
  endfunction

  // Rotation matrix of a random unit quaternion, sometimes slightly disturbed.
  function automatic rmq_in_t random_rotation();
    real w, x, y, z, n, e[9];
    rmq_in_t r;
    do begin
      w = unit_rand(); x = unit_rand(); y = unit_rand(); z = unit_rand();
      if ($urandom_range(3) == 0) w = w * 0.05;
      n = w*w + x*x + y*y + z*z;
    end while (n < 0.01);
    n = $sqrt(n);
    w = w / n; x = x / n; y = y / n; z = z / n;
    e[0] = 1 - 2*(y*y + z*z); e[1] = 2*(x*y - w*z); e[2] = 2*(x*z + w*y);
    e[3] = 2*(x*y + w*z); e[4] = 1 - 2*(x*x + z*z); e[5] = 2*(y*z - w*x);
    e[6] = 2*(x*z - w*y); e[7] = 2*(y*z + w*x); e[8] = 1 - 2*(x*x + y*y);
    if ($urandom_range(4) == 0)
      foreach (e[i]) e[i] = e[i] + unit_rand() * 0.02;
    r.m00 = fx(e[0]); r.m01 = fx(e[1]); r.m02 = fx(e[2]);
    r.m10 = fx(e[3]); r.m11 = fx(e[4]); r.m12 = fx(e[5]);
    r.m20 = fx(e[6]); r.m21 = fx(e[7]); r.m22 = fx(e[8]);
    return r;
  endfunction

  function automatic logic [31:0] rand_in_range();
    return 32'($urandom_range(2 * ONE) - ONE);
  endfunction

  function automatic rmq_in_t random_matrix();
    rmq_in_t r;
    int      pick;
    pick = $urandom_range(99);
    if (pick < 75) return random_rotation();
    if (pick < 95) begin
      r = {rand_in_range(), rand_in_range(), rand_in_range(), rand_in_range(),
           rand_in_range(), rand_in_range(), rand_in_range(), rand_in_range(),
           rand_in_range()};
      return r;
    end
    // raw words beyond the nominal range
    r = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
         $urandom(), $urandom(), $urandom(), $urandom()};
    return r;
  endfunction

  // Sender: directed matrices first, then random ones.
  initial begin
    rmq_in_t req_q[$];
    rmq_in_t r;
    int      gap;
    logic [31:0] p, h, z;
    p = ONE[31:0]; h = 32'(ONE / 2); z = 32'd0;
    req_q.push_back(diag(p, p, p));                 // identity
    req_q.push_back(diag(p, -p, -p));               // half turn about x
    req_q.push_back(diag(-p, p, -p));               // half turn about y
    req_q.push_back(diag(-p, -p, p));               // half turn about z
    req_q.push_back(diag(z, z, -p));                // tie between m00 and m11
    req_q.push_back(diag(-h, -p, -h));              // tie between m00 and m22
    req_q.push_back(diag(-p, -h, -h));              // tie between m11 and m22
    req_q.push_back(diag(z, z, z));                 // zero trace
    req_q.push_back(rmq_in_t'{default: p});         // all plus one
    req_q.push_back(rmq_in_t'{default: -p});        // all minus one
    r = diag(z, z, z); r.m21 = p; r.m12 = -p; r.m02 = -p; r.m20 = p;
    req_q.push_back(r);                             // saturate positive and negative
    r = diag(z, z, z); r.m21 = -p; r.m12 = p; r.m10 = -p; r.m01 = p;
    req_q.push_back(r);                             // saturate negative
    r = diag(-p, -p, p); r.m01 = p; r.m10 = p; r.m02 = -p; r.m20 = -p;
    req_q.push_back(r);                             // z pivot with off-diagonal sums
    req_q.push_back(rmq_in_t'{default: 32'h7fffffff});  // largest words
    req_q.push_back(rmq_in_t'{default: 32'h80000000});  // smallest words
    req_q.push_back(diag(32'h7fffffff, 32'h80000000, 32'h80000000));
    for (int i = 0; i < ITEMS; i++) req_q.push_back(random_matrix());

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    foreach (req_q[i]) begin
      gap = (i > 500 && i < 700) ? 0 : (($urandom_range(99) < 11) ? 1 : 0);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= req_q[i];
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
    in_valid <= 1'b0;
    sent_all = 1'b1;
  end

  // Receiver: random stalls, one long hold-off, one calm stretch.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= 300 && cyc < 700) out_ready <= 1'b0;
    else if (cyc >= 1000 && cyc < 1400) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= 11);
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Verdict once every request has been answered.
  initial begin
    wait (sent_all);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/rmq_pkg.sv
hw/rtl/rmq_prep.sv
hw/rtl/rmq_sqrt.sv
hw/rtl/rmq_div.sv
hw/rtl/rotation_matrix_to_quaternion_top.sv
dv/rmq_checker.sv
dv/tb_rotation_matrix_to_quaternion_top.sv
